// File: hdl/frot_pkg.sv
`default_nettype none

package frot_pkg;

  localparam int unsigned PIX_W = 24;
  localparam int unsigned DIM_W = 9;
  localparam int unsigned IDX_W = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W = DIM_W;

  localparam int unsigned MAX_DIM_DEF = 256;
  localparam int unsigned MAX_PIXELS_DEF = 65536;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  localparam logic MODE_ROT180 = 1'b0;
  localparam logic MODE_ROT90 = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              in_range;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [PIX_W-1:0]  pixel;
  } cmd_t;

  typedef struct packed {
    logic              last;
    logic [PIX_W-1:0]  pixel;
  } res_t;

  typedef struct packed {
    logic [QCNT_W-1:0] out_cnt;
    logic              rd_pend;
  } stat_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                               input int unsigned max_dim);
    logic [DIM_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (int'(raw) > int'(max_dim)) begin
      res = DIM_W'(max_dim);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/frot_ram.sv
`default_nettype none

module frot_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/frot_queue.sv
`default_nettype none

module frot_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             data_i,
  input  wire logic                         pop_i,
  output logic      [WIDTH-1:0]             data_o,
  output logic      [frot_pkg::QCNT_W-1:0]  count_o
);

  localparam int unsigned DEPTH = frot_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = frot_pkg::QPTR_W;
  localparam int unsigned CW = frot_pkg::QCNT_W;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// File: hdl/frot_front.sv
`default_nettype none

module frot_front #(
  parameter int unsigned MAX_DIM = frot_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_PIXELS = frot_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [frot_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [frot_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [frot_pkg::PIX_W-1:0]      s_axis_tdata,
  input  wire logic                            s_axis_tuser,
  input  wire logic                            room_i,
  output logic                                 push_o,
  output frot_pkg::cmd_t                       cmd_o
);

  localparam int unsigned DW = frot_pkg::DIM_W;
  localparam int unsigned IW = frot_pkg::IDX_W;

  logic [DW-1:0] width_q, height_q;
  logic          mode_q;
  logic [IW-1:0] load_idx_q, load_idx_d;
  logic [DW-1:0] col_q, col_d, row_q, row_d;

  logic [DW-1:0] w, h, ow, oh, col, row, sx, sy;
  logic [IW-1:0] total, li, li_next, rd_idx;
  logic          stale, last, accept;
  frot_pkg::kind_e kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= frot_pkg::DIM_RESET;
      height_q <= frot_pkg::DIM_RESET;
      mode_q <= frot_pkg::MODE_ROT180;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        frot_pkg::CFG_WIDTH: width_q <= cfg_wdata_i;
        frot_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        frot_pkg::CFG_MODE: mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign w = frot_pkg::eff_dim(width_q, MAX_DIM);
  assign h = frot_pkg::eff_dim(height_q, MAX_DIM);
  assign total = IW'(w) * IW'(h);

  assign s_axis_tready = room_i;
  assign accept = s_axis_tvalid && room_i;
  assign kind = frot_pkg::kind_e'(s_axis_tuser);

  always_comb begin
    li = (load_idx_q >= total) ? '0 : load_idx_q;
    li_next = li + IW'(1);
    if (li_next >= total) begin
      li_next = '0;
    end

    ow = (mode_q == frot_pkg::MODE_ROT90) ? h : w;
    oh = (mode_q == frot_pkg::MODE_ROT90) ? w : h;
    stale = (col_q >= ow) || (row_q >= oh);
    col = stale ? '0 : col_q;
    row = stale ? '0 : row_q;
    if (mode_q == frot_pkg::MODE_ROT90) begin
      sx = row;
      sy = h - DW'(1) - col;
    end else begin
      sx = w - DW'(1) - col;
      sy = h - DW'(1) - row;
    end
    rd_idx = IW'(sy) * IW'(w) + IW'(sx);
    last = (col == ow - DW'(1)) && (row == oh - DW'(1));
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (col == ow - DW'(1)) begin
      col_d = '0;
      row_d = row + DW'(1);
    end else begin
      col_d = col + DW'(1);
      row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (kind == frot_pkg::KIND_LOAD) begin
        load_idx_q <= li_next;
      end else begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_comb begin
    cmd_o.kind = kind;
    if (kind == frot_pkg::KIND_LOAD) begin
      cmd_o.idx = li;
      cmd_o.last = 1'b0;
      cmd_o.pixel = s_axis_tdata;
    end else begin
      cmd_o.idx = rd_idx;
      cmd_o.last = last;
      cmd_o.pixel = '0;
    end
    cmd_o.in_range = (32'(cmd_o.idx) < MAX_PIXELS);
  end

  assign push_o = accept;

endmodule

`default_nettype wire

// File: hdl/frot_back.sv
`default_nettype none

module frot_back #(
  parameter int unsigned MAX_PIXELS = frot_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire frot_pkg::cmd_t              cmd_i,
  output logic                             cmd_pop_o,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [frot_pkg::PIX_W-1:0]       m_axis_tdata,
  output logic                             m_axis_tlast,
  output frot_pkg::stat_t                  stat_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_PIXELS);
  localparam int unsigned IW = frot_pkg::IDX_W;
  localparam int unsigned WIDE_W = (ADDR_W > IW) ? ADDR_W : IW;
  localparam int unsigned CW = frot_pkg::QCNT_W;
  localparam int unsigned SUM_W = CW + 1;
  localparam int unsigned RES_W = $bits(frot_pkg::res_t);

  logic [WIDE_W-1:0]         idx_wide;
  logic [ADDR_W-1:0]         addr;
  logic [frot_pkg::PIX_W-1:0] rdata;
  logic                      rd_pend_q, rd_pend_d;
  logic                      zero_q, last_q;
  logic [CW-1:0]             out_cnt;
  logic                      out_pop, credit, is_load;
  frot_pkg::res_t            res_in, res_out;

  assign idx_wide = WIDE_W'(cmd_i.idx);
  assign addr = idx_wide[ADDR_W-1:0];
  assign is_load = (cmd_i.kind == frot_pkg::KIND_LOAD);

  assign out_pop = (out_cnt != '0) && m_axis_tready;
  assign credit = (SUM_W'(out_cnt) + SUM_W'(rd_pend_q))
                  < (SUM_W'(frot_pkg::QUEUE_DEPTH) + SUM_W'(out_pop));
  assign cmd_pop_o = cmd_valid_i && (is_load || credit);
  assign rd_pend_d = cmd_pop_o && !is_load;

  frot_ram #(
    .WIDTH (frot_pkg::PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_pop_o && is_load && cmd_i.in_range),
    .waddr_i (addr),
    .wdata_i (cmd_i.pixel),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_d) begin
      zero_q <= !cmd_i.in_range;
      last_q <= cmd_i.last;
    end
  end

  assign res_in.last = last_q;
  assign res_in.pixel = zero_q ? '0 : rdata;

  frot_queue #(
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rd_pend_q),
    .data_i  (res_in),
    .pop_i   (out_pop),
    .data_o  (res_out),
    .count_o (out_cnt)
  );

  assign m_axis_tvalid = (out_cnt != '0);
  assign m_axis_tdata = res_out.pixel;
  assign m_axis_tlast = res_out.last;

  assign stat_o.out_cnt = out_cnt;
  assign stat_o.rd_pend = rd_pend_q;

endmodule

`default_nettype wire

// File: hdl/frame_rotator_90_180.sv
// Frame store with rotated readout. A transaction with tuser low writes its
// tdata pixel into the store at the next raster position of the source frame;
// one with tuser high asks for the next pixel of the frame rotated by 180 or
// by 90 degrees, which comes back on the master side with tlast on the final
// pixel of the frame. Loads produce no output. The block takes one
// transaction per clock while the command queue has room. A requested pixel
// passes the command queue, the registered read of the frame store and the
// output queue in turn. The user must set the source frame width, height and
// mode through the write port only while the block is idle; the block does not
// enforce this. Store entries that were never loaded read as undefined.
`default_nettype none

module frame_rotator_90_180 #(
  parameter int unsigned MAX_DIM = frot_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_PIXELS = frot_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [frot_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [frot_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: pixel_in[23:0].
  input  wire logic [frot_pkg::PIX_W-1:0]      s_axis_tdata,
  // Fields from bit 0: func.
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: pixel_out[23:0].
  output logic [frot_pkg::PIX_W-1:0]           m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int unsigned CMD_W = $bits(frot_pkg::cmd_t);

  logic                        push, pop;
  logic [frot_pkg::QCNT_W-1:0] cmd_cnt;
  frot_pkg::cmd_t              cmd_in, cmd_head;
  frot_pkg::stat_t             stat;

  frot_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .room_i        (cmd_cnt != frot_pkg::QCNT_W'(frot_pkg::QUEUE_DEPTH)),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  frot_queue #(
    .WIDTH (CMD_W)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .count_o (cmd_cnt)
  );

  frot_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_cnt != '0),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .stat_o        (stat)
  );

  // A read in flight must always have a free slot waiting in the output queue.
  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((frot_pkg::QCNT_W + 1)'(stat.out_cnt) + (frot_pkg::QCNT_W + 1)'(stat.rd_pend))
      <= (frot_pkg::QCNT_W + 1)'(frot_pkg::QUEUE_DEPTH))
    else $error("output queue credit exceeded");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
      stat.rd_pend |=> (stat.out_cnt != '0))
    else $error("store read did not reach the output queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop |-> (cmd_cnt != '0))
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire
